/* src/sha1_byte_stream_hash_assert.svh */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash: assertion macros
// Concurrent assertion shorthands shared by the hash block.
// ----------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASH_ASSERT_SVH
`define SHA1_BYTE_STREAM_HASH_ASSERT_SVH

// same-cycle implication, held off during reset
`define SHA1BS_ASSERT_NOW(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("sha1bs assertion failed");

// next-cycle implication, held off during reset
`define SHA1BS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("sha1bs assertion failed");

`endif

/* src/sha1bs_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash package
// Types, command and status structs and constants shared by the hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1bs_pkg;

  typedef logic [31:0]      word_t;
  typedef logic [4:0][31:0] chain_t;

  localparam chain_t ChainIv = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                32'hEFCDAB89, 32'h67452301};

  localparam word_t RoundK0 = 32'h5A827999;
  localparam word_t RoundK1 = 32'h6ED9EBA1;
  localparam word_t RoundK2 = 32'h8F1BBCDC;
  localparam word_t RoundK3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte     = 8'h80;
  localparam logic [5:0] LengthFill  = 6'd56;
  localparam logic [6:0] RoundLast   = 7'd79;
  localparam logic [2:0] LastWordIdx = 3'd4;

  // source of the byte shifted into the block buffer
  typedef logic [1:0] byte_sel_t;
  localparam byte_sel_t SelData = 2'd0;
  localparam byte_sel_t SelPad  = 2'd1;
  localparam byte_sel_t SelZero = 2'd2;
  localparam byte_sel_t SelLen  = 2'd3;

  typedef struct packed {
    logic      load_byte;
    byte_sel_t byte_sel;
    logic      count_msg;
    logic      comp_init;
    logic      round_en;
    logic      comp_add;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
    logic round_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* src/sha1_byte_stream_hash.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash
// Hashes a byte stream into a 160-bit SHA-1 digest, five words per message.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid_i/in_ready_o   data_byte_i, has_byte_i, end_of_message_i
//  out      out_valid_o/out_ready_i digest_word_o, word_index_o, last_word_o
//
//  An item that does not complete a block is shifted into the buffer; one that
//  fills a 64-byte block starts a compression (load, init, 80 rounds, chaining
//  add) and the input is held until it ends. An end item adds padding (0x80,
//  zero fill, 64-bit length) byte by byte, with one or two compressions.
//  The digest sits in its own buffer, so the next message is taken while it
//  drains; a stalled output only blocks once the next message finishes.
//  Reset brings the chaining words to the SHA-1 initial values at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha1_byte_stream_hash_assert.svh"

module sha1_byte_stream_hash import sha1bs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  chain_t     chain;
  logic       obuf_load;
  logic       obuf_busy;

  sha1bs_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .status_i         (dp_status),
    .obuf_busy_i      (obuf_busy),
    .cmd_o            (dp_cmd),
    .obuf_load_o      (obuf_load)
  );

  sha1bs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .data_byte_i (data_byte_i),
    .status_o    (dp_status),
    .chain_o     (chain)
  );

  sha1bs_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (obuf_load),
    .chain_i       (chain),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o),
    .busy_o        (obuf_busy)
  );

  `SHA1BS_ASSERT_NEXT(a_load_starts_word0, clk_i, rst_ni, obuf_load,
                      out_valid_o && (word_index_o == 3'd0))
  `SHA1BS_ASSERT_NEXT(a_last_drains, clk_i, rst_ni,
                      out_valid_o && out_ready_i && last_word_o, !out_valid_o)
  `SHA1BS_ASSERT_NOW(a_no_load_over_busy, clk_i, rst_ni, obuf_load, !obuf_busy)

endmodule

`default_nettype wire

/* src/sha1bs_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash controller
// Sequences byte loading, padding, the 80 rounds and the digest hand-over.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1bs_ctrl import sha1bs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       has_byte_i,
  input  logic       end_of_message_i,
  input  dp_status_t status_i,
  input  logic       obuf_busy_i,
  output dp_cmd_t    cmd_o,
  output logic       obuf_load_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD80  = 3'd1;
  localparam logic [2:0] S_ZERO   = 3'd2;
  localparam logic [2:0] S_LEN    = 3'd3;
  localparam logic [2:0] S_CINIT  = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_CADD   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cmd_o       = '0;
    obuf_load_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.byte_sel = SelData;
        if (accept) begin
          cmd_o.load_byte = has_byte_i;
          cmd_o.count_msg = has_byte_i;
          if (has_byte_i && status_i.fill_last) begin
            state_d = S_CINIT;
            ret_d   = end_of_message_i ? S_PAD80 : S_IDLE;
          end else if (end_of_message_i) begin
            state_d = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_sel  = SelPad;
        if (status_i.fill_last) begin
          state_d = S_CINIT;
          ret_d   = S_ZERO;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        cmd_o.byte_sel = SelZero;
        if (status_i.fill_at_len) begin
          state_d = S_LEN;
        end else begin
          cmd_o.load_byte = 1'b1;
          if (status_i.fill_last) begin
            state_d = S_CINIT;
            ret_d   = S_ZERO;
          end
        end
      end
      S_LEN: begin
        cmd_o.load_byte = 1'b1;
        cmd_o.byte_sel  = SelLen;
        if (status_i.fill_last) begin
          state_d = S_CINIT;
          ret_d   = S_FINISH;
        end
      end
      S_CINIT: begin
        cmd_o.comp_init = 1'b1;
        state_d         = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (status_i.round_last) begin
          state_d = S_CADD;
        end
      end
      S_CADD: begin
        cmd_o.comp_add = 1'b1;
        state_d        = ret_q;
      end
      S_FINISH: begin
        // hold until the previous digest has been drained
        if (!obuf_busy_i) begin
          cmd_o.finish = 1'b1;
          obuf_load_o  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

`default_nettype wire

/* src/sha1bs_datapath.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash datapath
// Block buffer and schedule window, round unit, chaining words and length.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1bs_datapath import sha1bs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  logic [7:0] data_byte_i,
  output dp_status_t status_o,
  output chain_t     chain_o
);

  localparam logic [6:0] RoundEnd0 = 7'd20;
  localparam logic [6:0] RoundEnd1 = 7'd40;
  localparam logic [6:0] RoundEnd2 = 7'd60;

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  chain_t           chain_q;
  chain_t           work_q;   // a..e at indices 0..4
  logic [15:0][31:0] win_q;   // index 0 is the oldest word
  logic [5:0]       fill_q;
  logic [60:0]      msg_q;
  logic [6:0]       round_q;

  logic [63:0] len_bits;
  logic [7:0]  byte_in;
  word_t       f_val, k_val, tmp_val, sched_new;

  assign len_bits = {msg_q, 3'b000};

  always_comb begin
    case (cmd_i.byte_sel)
      SelData: byte_in = data_byte_i;
      SelPad:  byte_in = PadByte;
      SelZero: byte_in = 8'h00;
      SelLen:  byte_in = len_bits[{~fill_q[2:0], 3'b000} +: 8];
      default: byte_in = 8'h00;
    endcase
  end

  always_comb begin
    if (round_q < RoundEnd0) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      k_val = RoundK0;
    end else if (round_q < RoundEnd1) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = RoundK1;
    end else if (round_q < RoundEnd2) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) |
              (work_q[2] & work_q[3]);
      k_val = RoundK2;
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = RoundK3;
    end
  end

  assign tmp_val   = rotl(work_q[0], 5) + f_val + work_q[4] + k_val + win_q[0];
  assign sched_new = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= ChainIv;
      work_q  <= '0;
      fill_q  <= '0;
      msg_q   <= '0;
      round_q <= '0;
    end else begin
      if (cmd_i.load_byte) begin
        fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.comp_init) begin
        work_q  <= chain_q;
        round_q <= '0;
      end else if (cmd_i.round_en) begin
        work_q  <= {work_q[3], work_q[2], rotl(work_q[1], 30), work_q[0], tmp_val};
        round_q <= round_q + 7'd1;
      end
      if (cmd_i.finish) begin
        chain_q <= ChainIv;
        msg_q   <= '0;
      end else begin
        if (cmd_i.count_msg) begin
          msg_q <= msg_q + 61'd1;
        end
        if (cmd_i.comp_add) begin
          for (int i = 0; i < 5; i++) begin
            chain_q[i] <= chain_q[i] + work_q[i];
          end
        end
      end
    end
  end

  // block buffer: bytes shift in big-endian, rounds shift whole words
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[15] <= {win_q[15][23:0], byte_in};
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= sched_new;
    end
  end

  assign status_o.fill_last   = &fill_q;
  assign status_o.fill_at_len = (fill_q == LengthFill);
  assign status_o.round_last  = (round_q == RoundLast);
  assign chain_o              = chain_q;

endmodule

`default_nettype wire

/* src/sha1bs_outbuf.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash output buffer
// Holds a finished digest and hands it out one word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1bs_outbuf import sha1bs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  chain_t      chain_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        busy_o
);

  chain_t     digest_q;
  logic       valid_q;
  logic [2:0] idx_q;
  logic       xfer;

  assign xfer = valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (xfer) begin
      if (idx_q == LastWordIdx) begin
        valid_q <= 1'b0;
      end
      idx_q <= idx_q + 3'd1;
    end
  end

  // advance to the next word after each transfer
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      digest_q <= chain_i;
    end else if (xfer) begin
      digest_q <= digest_q >> 32;
    end
  end

  assign out_valid_o   = valid_q;
  assign digest_word_o = digest_q[0];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == LastWordIdx);
  assign busy_o        = valid_q;

endmodule

`default_nettype wire

/* tb/sv/sha1_digest_checker.sv */
// ----------------------------------------------------------------------------
// SHA-1 digest checker
// Watches both channels of the byte stream hash, recomputes the digest of
// every message from the accepted bytes and compares each digest word
// transfer with the oldest word still awaited.
// ----------------------------------------------------------------------------
module sha1_digest_checker import sha1bs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          mismatch_count_o,
  output int          words_pending_o
);

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_entry_t;

  digest_entry_t digest_words_q[$];

  word_t       chain[5];
  word_t       sched[16];
  logic [5:0]  fill;
  logic [60:0] msg_len;
  int          mismatches = 0;

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 5; i++) chain[i] = ChainIv[i];
    for (int i = 0; i < 16; i++) sched[i] = '0;
    fill    = '0;
    msg_len = '0;
  endfunction

  function automatic void compress_block();
    word_t a, b, c, d, e, f, k, w, sum;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        w = sched[t];
      end else begin
        w = rotl(sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^
                 sched[(t - 14) & 15] ^ sched[t & 15], 1);
        sched[t & 15] = w;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      sum = rotl(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = sum;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // pack big-endian into the block buffer, compress on a full block
  function automatic void absorb_byte(logic [7:0] byte_val);
    int unsigned idx;
    int unsigned sh;
    idx = fill[5:2];
    sh  = 24 - 8 * int'(fill[1:0]);
    if (fill[1:0] == 2'd0) sched[idx] = word_t'(byte_val) << sh;
    else sched[idx] |= word_t'(byte_val) << sh;
    fill = fill + 6'd1;
    if (fill == 6'd0) compress_block();
  endfunction

  function automatic void close_message();
    logic [63:0]   bit_len;
    digest_entry_t entry;
    bit_len = {msg_len, 3'b000};
    absorb_byte(PadByte);
    // no room for the length: zero fill out to a second block
    if (fill > LengthFill) begin
      while (fill != 6'd0) absorb_byte(8'h00);
    end
    while (fill < LengthFill) absorb_byte(8'h00);
    sched[14] = bit_len[63:32];
    sched[15] = bit_len[31:0];
    fill = '0;
    compress_block();
    for (int i = 0; i < 5; i++) begin
      entry.word  = chain[i];
      entry.index = 3'(i);
      entry.last  = (3'(i) == LastWordIdx);
      digest_words_q.push_back(entry);
    end
    restart_hash();
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    digest_entry_t want;
    if (!rst_ni) begin
      restart_hash();
      digest_words_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (digest_words_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected digest word %08h index %0d last %0b", $time,
                   digest_word_i, word_index_i, last_word_i);
        end else begin
          want = digest_words_q.pop_front();
          if (want.word !== digest_word_i || want.index !== word_index_i ||
              want.last !== last_word_i) begin
            mismatches++;
            $display("%0t: digest word expected %08h/%0d/%0b, got %08h/%0d/%0b",
                     $time, want.word, want.index, want.last,
                     digest_word_i, word_index_i, last_word_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (has_byte_i) begin
          absorb_byte(data_byte_i);
          msg_len = msg_len + 61'd1;
        end
        if (end_of_message_i) close_message();
      end
    end
    mismatch_count_o <= mismatches;
    words_pending_o  <= digest_words_q.size();
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// SHA-1 byte stream hash testbench
// Feeds directed and random messages in bursts, stalls the digest side on
// shifting patterns with one long hold-off, and takes the verdict from the
// digest checker beside the block.
// ----------------------------------------------------------------------------
module tb;

  localparam int StallLimit = 20000;

  typedef enum int {
    DrainFree,
    DrainCoin,
    DrainSparse,
    DrainStarved
  } drain_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        has_byte_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  int mismatch_count;
  int words_pending;
  int burst_left = 0;
  int message_items = 0;
  int messages_done = 0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  sha1_byte_stream_hash dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  sha1_digest_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digest_word_i    (digest_word_o),
    .word_index_i     (word_index_o),
    .last_word_i      (last_word_o),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic [7:0] byte_val, input logic with_byte,
                           input logic closes);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    data_byte_i      <= byte_val;
    has_byte_i       <= with_byte;
    end_of_message_i <= closes;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (with_byte || closes) message_items++;
  endtask

  task automatic send_message(input int unsigned len, input logic end_with_byte);
    int unsigned plain;
    plain = (end_with_byte && len > 0) ? len - 1 : len;
    for (int unsigned i = 0; i < plain; i++) begin
      // sprinkle items that carry nothing
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    if (end_with_byte && len > 0) send_item(8'($urandom), 1'b1, 1'b1);
    else send_item(8'($urandom), 1'b0, 1'b1);
    messages_done++;
  endtask

  function automatic int unsigned pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 12);
      5:             return $urandom_range(13, 40);
      6, 7:          return $urandom_range(55, 65);
      default:       return $urandom_range(0, 2);
    endcase
  endfunction

  initial begin : stimulus
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty message
    send_item(8'h00, 1'b0, 1'b1);
    // idle item on its own, then "abc" closed by an item without a byte
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    // extremes, closing item carries the last byte
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);
    // one-byte message
    send_item(8'hFF, 1'b1, 1'b1);
    // idle item in the middle of a message
    send_item(8'h12, 1'b1, 1'b0);
    send_item(8'h34, 1'b0, 1'b0);
    send_item(8'h56, 1'b1, 1'b1);

    message_items = 0;
    messages_done = 0;
    while (message_items < 130 || messages_done < 6) begin
      send_message(pick_length(), 1'($urandom_range(0, 1)));
    end
    in_valid_i <= 1'b0;

    while (words_pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : drain
    drain_mode_e mode;
    int          tick;
    tick = 0;
    @(posedge rst_ni);
    repeat (150) begin
      @(negedge clk_i);
      out_ready_i <= 1'($urandom_range(0, 1));
    end
    // long hold-off: let the digest buffer fill and back up the input
    @(negedge clk_i);
    out_ready_i <= 1'b0;
    repeat (3000) @(negedge clk_i);
    forever begin
      mode = drain_mode_e'($urandom_range(0, 3));
      repeat (48) begin
        @(negedge clk_i);
        tick++;
        case (mode)
          DrainFree:    out_ready_i <= 1'b1;
          DrainCoin:    out_ready_i <= 1'($urandom_range(0, 1));
          DrainSparse:  out_ready_i <= (tick % 4 == 0);
          DrainStarved: out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
